// File: rtl/core/sha512_384_hash_assert.svh
// Assertion macros shared by the hash core.
`ifndef SHA512_384_HASH_ASSERT_SVH
`define SHA512_384_HASH_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define SHA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define SHA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: rtl/core/sha_pkg.sv
`default_nettype none
package sha_pkg;

   localparam int WordWidth  = 64;
   localparam int NumRounds  = 80;
   localparam int HashWords  = 8;
   localparam int BlockWords = 16;

   typedef logic [WordWidth-1:0] word_type;
   typedef logic [6:0]           round_type;
   typedef logic [6:0]           pos_type;

   localparam pos_type LenPos = 7'd112;
   localparam logic [7:0] PadByte = 8'h80;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_ADD,
      ST_PAD80,
      ST_PADZERO,
      ST_LEN,
      ST_OUT
   } state_type;

   function automatic word_type iv_word(input logic mode, input logic [2:0] i);
      word_type r;
      r = '0;
      if (!mode) begin
         unique case (i)
            3'd0: r = 64'h6a09e667f3bcc908;
            3'd1: r = 64'hbb67ae8584caa73b;
            3'd2: r = 64'h3c6ef372fe94f82b;
            3'd3: r = 64'ha54ff53a5f1d36f1;
            3'd4: r = 64'h510e527fade682d1;
            3'd5: r = 64'h9b05688c2b3e6c1f;
            3'd6: r = 64'h1f83d9abfb41bd6b;
            3'd7: r = 64'h5be0cd19137e2179;
            default: r = '0;
         endcase
      end else begin
         unique case (i)
            3'd0: r = 64'hcbbb9d5dc1059ed8;
            3'd1: r = 64'h629a292a367cd507;
            3'd2: r = 64'h9159015a3070dd17;
            3'd3: r = 64'h152fecd8f70e5939;
            3'd4: r = 64'h67332667ffc00b31;
            3'd5: r = 64'h8eb44a8768581511;
            3'd6: r = 64'hdb0c2e0d64f98fa7;
            3'd7: r = 64'h47b5481dbefa4fa4;
            default: r = '0;
         endcase
      end
      return r;
   endfunction

   function automatic word_type round_k(input round_type t);
      word_type k;
      k = '0;
      unique case (t)
         7'd0:  k = 64'h428a2f98d728ae22;  7'd1:  k = 64'h7137449123ef65cd;
         7'd2:  k = 64'hb5c0fbcfec4d3b2f;  7'd3:  k = 64'he9b5dba58189dbbc;
         7'd4:  k = 64'h3956c25bf348b538;  7'd5:  k = 64'h59f111f1b605d019;
         7'd6:  k = 64'h923f82a4af194f9b;  7'd7:  k = 64'hab1c5ed5da6d8118;
         7'd8:  k = 64'hd807aa98a3030242;  7'd9:  k = 64'h12835b0145706fbe;
         7'd10: k = 64'h243185be4ee4b28c;  7'd11: k = 64'h550c7dc3d5ffb4e2;
         7'd12: k = 64'h72be5d74f27b896f;  7'd13: k = 64'h80deb1fe3b1696b1;
         7'd14: k = 64'h9bdc06a725c71235;  7'd15: k = 64'hc19bf174cf692694;
         7'd16: k = 64'he49b69c19ef14ad2;  7'd17: k = 64'hefbe4786384f25e3;
         7'd18: k = 64'h0fc19dc68b8cd5b5;  7'd19: k = 64'h240ca1cc77ac9c65;
         7'd20: k = 64'h2de92c6f592b0275;  7'd21: k = 64'h4a7484aa6ea6e483;
         7'd22: k = 64'h5cb0a9dcbd41fbd4;  7'd23: k = 64'h76f988da831153b5;
         7'd24: k = 64'h983e5152ee66dfab;  7'd25: k = 64'ha831c66d2db43210;
         7'd26: k = 64'hb00327c898fb213f;  7'd27: k = 64'hbf597fc7beef0ee4;
         7'd28: k = 64'hc6e00bf33da88fc2;  7'd29: k = 64'hd5a79147930aa725;
         7'd30: k = 64'h06ca6351e003826f;  7'd31: k = 64'h142929670a0e6e70;
         7'd32: k = 64'h27b70a8546d22ffc;  7'd33: k = 64'h2e1b21385c26c926;
         7'd34: k = 64'h4d2c6dfc5ac42aed;  7'd35: k = 64'h53380d139d95b3df;
         7'd36: k = 64'h650a73548baf63de;  7'd37: k = 64'h766a0abb3c77b2a8;
         7'd38: k = 64'h81c2c92e47edaee6;  7'd39: k = 64'h92722c851482353b;
         7'd40: k = 64'ha2bfe8a14cf10364;  7'd41: k = 64'ha81a664bbc423001;
         7'd42: k = 64'hc24b8b70d0f89791;  7'd43: k = 64'hc76c51a30654be30;
         7'd44: k = 64'hd192e819d6ef5218;  7'd45: k = 64'hd69906245565a910;
         7'd46: k = 64'hf40e35855771202a;  7'd47: k = 64'h106aa07032bbd1b8;
         7'd48: k = 64'h19a4c116b8d2d0c8;  7'd49: k = 64'h1e376c085141ab53;
         7'd50: k = 64'h2748774cdf8eeb99;  7'd51: k = 64'h34b0bcb5e19b48a8;
         7'd52: k = 64'h391c0cb3c5c95a63;  7'd53: k = 64'h4ed8aa4ae3418acb;
         7'd54: k = 64'h5b9cca4f7763e373;  7'd55: k = 64'h682e6ff3d6b2b8a3;
         7'd56: k = 64'h748f82ee5defb2fc;  7'd57: k = 64'h78a5636f43172f60;
         7'd58: k = 64'h84c87814a1f0ab72;  7'd59: k = 64'h8cc702081a6439ec;
         7'd60: k = 64'h90befffa23631e28;  7'd61: k = 64'ha4506cebde82bde9;
         7'd62: k = 64'hbef9a3f7b2c67915;  7'd63: k = 64'hc67178f2e372532b;
         7'd64: k = 64'hca273eceea26619c;  7'd65: k = 64'hd186b8c721c0c207;
         7'd66: k = 64'heada7dd6cde0eb1e;  7'd67: k = 64'hf57d4f7fee6ed178;
         7'd68: k = 64'h06f067aa72176fba;  7'd69: k = 64'h0a637dc5a2c898a6;
         7'd70: k = 64'h113f9804bef90dae;  7'd71: k = 64'h1b710b35131c471b;
         7'd72: k = 64'h28db77f523047d84;  7'd73: k = 64'h32caab7b40c72493;
         7'd74: k = 64'h3c9ebe0a15c9bebc;  7'd75: k = 64'h431d67c49c100d4c;
         7'd76: k = 64'h4cc5d4becb3e42b6;  7'd77: k = 64'h597f299cfc657e2a;
         7'd78: k = 64'h5fcb6fab3ad6faec;  7'd79: k = 64'h6c44198c4a475817;
         default: k = '0;
      endcase
      return k;
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/sha_round.sv
`default_nettype none
// One SHA-512 round plus the next message schedule word.
module sha_round (
   input  sha_pkg::word_type  v_in   [8],
   input  sha_pkg::word_type  w_tap0,
   input  sha_pkg::word_type  w_tap1,
   input  sha_pkg::word_type  w_tap9,
   input  sha_pkg::word_type  w_tap14,
   input  logic               expand,
   input  sha_pkg::word_type  k,
   output sha_pkg::word_type  v_out  [8],
   output sha_pkg::word_type  w_next
);
   import sha_pkg::*;

   function automatic word_type rotr(input word_type x, input int n);
      return (x >> n) | (x << (WordWidth - n));
   endfunction

   word_type s0, s1, w_cur, t1, t2, ch, maj, bs0, bs1;

   always_comb begin
      s1     = rotr(w_tap14, 19) ^ rotr(w_tap14, 61) ^ (w_tap14 >> 6);
      s0     = rotr(w_tap1, 1) ^ rotr(w_tap1, 8) ^ (w_tap1 >> 7);
      w_cur  = expand ? (s1 + w_tap9 + s0 + w_tap0) : w_tap0;
      w_next = w_cur;
      bs1    = rotr(v_in[4], 14) ^ rotr(v_in[4], 18) ^ rotr(v_in[4], 41);
      ch     = (v_in[4] & v_in[5]) ^ (~v_in[4] & v_in[6]);
      bs0    = rotr(v_in[0], 28) ^ rotr(v_in[0], 34) ^ rotr(v_in[0], 39);
      maj    = (v_in[0] & v_in[1]) ^ (v_in[0] & v_in[2]) ^ (v_in[1] & v_in[2]);
      t1     = v_in[7] + bs1 + ch + k + w_cur;
      t2     = bs0 + maj;
      v_out[7] = v_in[6];
      v_out[6] = v_in[5];
      v_out[5] = v_in[4];
      v_out[4] = v_in[3] + t1;
      v_out[3] = v_in[2];
      v_out[2] = v_in[1];
      v_out[1] = v_in[0];
      v_out[0] = t1 + t2;
   end

endmodule
`default_nettype wire

// File: rtl/core/sha512_384_hash.sv
// Input: one message byte per cycle while idle; a full 128-byte block then runs
// 80 rounds through one round unit and one chaining add.
// Last beat: pad bytes are shifted in one per cycle, then the length is
// loaded and compressed, then 8 (SHA-512) or 6 (SHA-384) digest beats.
// Input is stalled while a block is compressed or the digest is output.
// Reset: synchronous; mode SHA-512, SHA-512 initial values, count cleared.
`default_nettype none
module sha512_384_hash (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_write_en,
   input  wire logic              csr_write_data,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [7:0]        req_data_byte,
   input  wire logic              req_byte_valid,
   input  wire logic              req_last,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output sha_pkg::word_type      rsp_digest_word,
   output logic [2:0]             rsp_word_index,
   output logic                   rsp_last_word
);
   import sha_pkg::*;
   `include "sha512_384_hash_assert.svh"

   state_type state_ff, state_in, ret_ff, ret_in;
   logic      mode_ff;
   word_type  hash_ff [8];
   word_type  v_ff    [8];
   word_type  w_ff    [16];
   pos_type   pos_ff, pos_in;
   round_type rnd_ff, rnd_in;
   logic [2:0] idx_ff, idx_in;
   word_type  cnt_lo_ff, cnt_hi_ff;
   word_type  v_next [8];
   word_type  w_new;
   logic      in_beat, out_beat, shift_en, load_len, start_cmp, reload;
   logic [7:0] shift_byte;
   logic [2:0] last_idx;

   sha_round u_round (
      .v_in   (v_ff),
      .w_tap0 (w_ff[0]),
      .w_tap1 (w_ff[1]),
      .w_tap9 (w_ff[9]),
      .w_tap14(w_ff[14]),
      .expand (rnd_ff >= round_type'(BlockWords)),
      .k      (round_k(rnd_ff)),
      .v_out  (v_next),
      .w_next (w_new)
   );

   assign in_beat  = req_valid && !req_stall;
   assign out_beat = rsp_valid && !rsp_stall;
   assign last_idx = mode_ff ? 3'd5 : 3'd7;

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = (state_ff == ST_OUT);
   assign rsp_digest_word = hash_ff[idx_ff];
   assign rsp_word_index  = idx_ff;
   assign rsp_last_word   = (idx_ff == last_idx);

   always_comb begin
      state_in   = state_ff;
      ret_in     = ret_ff;
      pos_in     = pos_ff;
      rnd_in     = rnd_ff;
      idx_in     = idx_ff;
      shift_en   = 1'b0;
      shift_byte = req_data_byte;
      load_len   = 1'b0;
      start_cmp  = 1'b0;
      reload     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (in_beat) begin
               if (req_byte_valid) begin
                  shift_en = 1'b1;
                  pos_in   = pos_ff + 7'd1;
               end
               if (req_byte_valid && pos_ff == 7'h7f) begin
                  start_cmp = 1'b1;
                  ret_in    = req_last ? ST_PAD80 : ST_IDLE;
                  state_in  = ST_ROUND;
               end else if (req_last) begin
                  state_in = ST_PAD80;
               end
            end
         end
         ST_ROUND: begin
            rnd_in = rnd_ff + 7'd1;
            if (rnd_ff == round_type'(NumRounds - 1)) begin
               rnd_in   = '0;
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            state_in = ret_ff;
            idx_in   = '0;
         end
         ST_PAD80, ST_PADZERO: begin
            if (state_ff == ST_PADZERO && pos_ff == LenPos) begin
               state_in = ST_LEN;
            end else begin
               shift_en   = 1'b1;
               shift_byte = (state_ff == ST_PAD80) ? PadByte : 8'd0;
               pos_in     = pos_ff + 7'd1;
               if (pos_ff == 7'h7f) begin
                  start_cmp = 1'b1;
                  ret_in    = ST_PADZERO;
                  state_in  = ST_ROUND;
               end else begin
                  state_in = ST_PADZERO;
               end
            end
         end
         ST_LEN: begin
            load_len  = 1'b1;
            pos_in    = '0;
            start_cmp = 1'b1;
            ret_in    = ST_OUT;
            state_in  = ST_ROUND;
         end
         ST_OUT: begin
            if (out_beat) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == last_idx) begin
                  reload   = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff   <= ST_IDLE;
         rnd_ff   <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         rnd_ff   <= rnd_in;
         idx_ff   <= idx_in;
      end
   end

   // Mode, chaining words, length count and byte position.
   always_ff @(posedge clock) begin
      if (reset || csr_write_en || reload) begin
         if (reset) begin
            mode_ff <= 1'b0;
         end else if (csr_write_en) begin
            mode_ff <= csr_write_data;
         end
         for (int i = 0; i < HashWords; i++) begin
            hash_ff[i] <= iv_word(reset ? 1'b0 : (csr_write_en ? csr_write_data : mode_ff),
                                  3'(i));
         end
         cnt_lo_ff <= '0;
         cnt_hi_ff <= '0;
         pos_ff    <= '0;
      end else begin
         pos_ff <= pos_in;
         if (in_beat && req_byte_valid) begin
            cnt_lo_ff <= cnt_lo_ff + word_type'(8);
            if (cnt_lo_ff >= {{(WordWidth-3){1'b1}}, 3'b000}) begin
               cnt_hi_ff <= cnt_hi_ff + word_type'(1);
            end
         end
         if (state_ff == ST_ADD) begin
            for (int i = 0; i < HashWords; i++) begin
               hash_ff[i] <= hash_ff[i] + v_ff[i];
            end
         end
      end
   end

   // Working words and the block buffer / schedule shift line.
   always_ff @(posedge clock) begin
      if (start_cmp) begin
         for (int i = 0; i < HashWords; i++) v_ff[i] <= hash_ff[i];
      end else if (state_ff == ST_ROUND) begin
         for (int i = 0; i < HashWords; i++) v_ff[i] <= v_next[i];
      end
      if (shift_en) begin
         for (int i = 0; i < BlockWords - 1; i++) begin
            w_ff[i] <= {w_ff[i][WordWidth-9:0], w_ff[i+1][WordWidth-1:WordWidth-8]};
         end
         w_ff[BlockWords-1] <= {w_ff[BlockWords-1][WordWidth-9:0], shift_byte};
      end else if (load_len) begin
         for (int i = 0; i < BlockWords - 2; i++) w_ff[i] <= w_ff[i+2];
         w_ff[BlockWords-2] <= cnt_hi_ff;
         w_ff[BlockWords-1] <= cnt_lo_ff;
      end else if (state_ff == ST_ROUND) begin
         for (int i = 0; i < BlockWords - 1; i++) w_ff[i] <= w_ff[i+1];
         w_ff[BlockWords-1] <= w_new;
      end
   end

   `SHA_ASSERT_IMPL(a_no_rsp_when_ready, clock, reset, !req_stall, !rsp_valid)
   `SHA_ASSERT_IMPL(a_round_range, clock, reset, state_ff == ST_ROUND,
                    rnd_ff < round_type'(NumRounds))
   `SHA_ASSERT_IMPL(a_idx_mode, clock, reset, rsp_valid && mode_ff, rsp_word_index <= 3'd5)
   `SHA_ASSERT_NEXT(a_last_word_idle, clock, reset, out_beat && rsp_last_word,
                    state_ff == ST_IDLE)

endmodule
`default_nettype wire
